@@ rtl/core/bqid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqid_pkg
// Shared sizes and command codes for the bounded queue with indexed delete.
// ----------------------------------------------------------------------------
package bqid_pkg;

    // Storage depth and word width
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;

    // Position and count widths
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Capacity register
    localparam int              CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    // Command codes
    localparam int CMD_W = 2;
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_ENQ  = 2'd0;
    localparam t_cmd CMD_DEQ  = 2'd1;
    localparam t_cmd CMD_READ = 2'd2;
    localparam t_cmd CMD_DEL  = 2'd3;

endpackage

@@ rtl/core/bqid_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqid_if
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------

// Command channel
interface bqid_cmd_if;
    logic                        valid;
    logic                        ready;
    bqid_pkg::t_cmd              command;
    logic [bqid_pkg::DATA_W-1:0] item_value;
    logic [bqid_pkg::IDX_W-1:0]  index;

    modport source (output valid, command, item_value, index, input ready);
    modport sink   (input valid, command, item_value, index, output ready);
endinterface

// Result channel
interface bqid_res_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [bqid_pkg::DATA_W-1:0] item_out;
    logic [bqid_pkg::CNT_W-1:0]  count;
    logic                        empty_res;
    logic                        full_res;

    modport source (output valid, ok, item_out, count, empty_res, full_res, input ready);
    modport sink   (input valid, ok, item_out, count, empty_res, full_res, output ready);
endinterface

@@ rtl/core/bounded_queue_indexed_delete.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_queue_indexed_delete
// Bounded FIFO of data words with enqueue, dequeue, read-at and delete-at.
// ----------------------------------------------------------------------------
// Returns exactly one result per command, via the command register and then
// the result register. All entries are flip-flops with the head at position 0;
// dequeue and delete close the gap with a parallel one-place shift, so every
// command finishes in one pass through the execute logic; the rate is one
// item per cycle while the result side keeps taking transfers. Capacity is
// written via i_cfg_we / i_cfg_wdata; the user must write it only while the
// queue is idle; the block does not enforce it. Zero acts as one, values above
// the depth act as the depth; lowering it below the count keeps held words.
module bounded_queue_indexed_delete (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bqid_pkg::CAP_W-1:0]    i_cfg_wdata,
    bqid_cmd_if.sink                      i_cmd,
    bqid_res_if.source                    o_res
);

    localparam int DEPTH  = bqid_pkg::DEPTH;
    localparam int DATA_W = bqid_pkg::DATA_W;
    localparam int IDX_W  = bqid_pkg::IDX_W;
    localparam int CNT_W  = bqid_pkg::CNT_W;
    localparam int CAP_W  = bqid_pkg::CAP_W;

    // Capacity register
    logic [CAP_W-1:0] r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bqid_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Command register
    logic                 r_in_valid;
    bqid_pkg::t_cmd       r_in_cmd;
    logic [DATA_W-1:0]    r_in_val;
    logic [IDX_W-1:0]     r_in_idx;
    logic                 exec_go;
    logic                 r_out_valid;

    assign exec_go     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || exec_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_cmd <= i_cmd.command;
            r_in_val <= i_cmd.item_value;
            r_in_idx <= i_cmd.index;
        end
    end

    // Queue state
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0]  r_cnt;

    // Effective capacity: zero acts as one, saturate at depth
    logic [CNT_W-1:0] cap_eff;
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (32'(r_cap) > 32'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(r_cap);
        end
    end

    // Execute decode
    logic               idx_ok;
    logic               ok;
    logic               do_enq;
    logic               do_rm;
    logic [IDX_W-1:0]   pos;
    logic [DATA_W-1:0]  word;
    logic [CNT_W-1:0]   n_cnt;

    assign idx_ok = CNT_W'(r_in_idx) < r_cnt;

    always_comb begin
        ok     = 1'b0;
        do_enq = 1'b0;
        do_rm  = 1'b0;
        pos    = r_in_idx;
        case (r_in_cmd)
            bqid_pkg::CMD_ENQ: begin
                ok     = r_cnt < cap_eff;
                do_enq = ok;
            end
            bqid_pkg::CMD_DEQ: begin
                ok    = r_cnt != '0;
                do_rm = ok;
                pos   = '0;
            end
            bqid_pkg::CMD_READ: begin
                ok = idx_ok;
            end
            bqid_pkg::CMD_DEL: begin
                ok    = idx_ok;
                do_rm = ok;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Word out: zero for enqueue and failures
    assign word = (ok && r_in_cmd != bqid_pkg::CMD_ENQ) ? r_mem[pos] : '0;

    always_comb begin
        n_cnt = r_cnt;
        if (exec_go && do_enq) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (exec_go && do_rm) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Entry update: shift up behind the removed position, or append at tail
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (exec_go && do_rm && k < DEPTH - 1 && IDX_W'(k) >= pos) begin
                r_mem[k] <= r_mem[(k < DEPTH - 1) ? k + 1 : k];
            end else if (exec_go && do_enq && r_cnt == CNT_W'(k)) begin
                r_mem[k] <= r_in_val;
            end
        end
    end

    // Result register
    logic               r_ok;
    logic [DATA_W-1:0]  r_word;
    logic [CNT_W-1:0]   r_res_cnt;
    logic               r_empty;
    logic               r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_ok      <= ok;
            r_word    <= word;
            r_res_cnt <= n_cnt;
            r_empty   <= n_cnt == '0;
            r_full    <= n_cnt >= cap_eff;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.ok        = r_ok;
    assign o_res.item_out  = r_word;
    assign o_res.count     = r_res_cnt;
    assign o_res.empty_res = r_empty;
    assign o_res.full_res  = r_full;

endmodule

@@ dv/bounded_queue_indexed_delete_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_queue_indexed_delete_tb
// Self-checking bench for the bounded queue with indexed read and delete.
// ----------------------------------------------------------------------------
// A queue of pending commands feeds a clocked driver on the command channel.
// A shadow copy of the queue predicts each result when its command transfers,
// and a clocked monitor compares every result transfer, field by field, with
// the oldest prediction. Capacity is rewritten between phases while the block
// is drained, covering zero, one, the depth, a saturating value and a drop
// below the current count. Both channels idle at random, and one phase holds
// the result side off long enough to back up the command side.
// ----------------------------------------------------------------------------
module bounded_queue_indexed_delete_tb;

    localparam int DEPTH  = bqid_pkg::DEPTH;
    localparam int DATA_W = bqid_pkg::DATA_W;
    localparam int IDX_W  = bqid_pkg::IDX_W;
    localparam int CNT_W  = bqid_pkg::CNT_W;
    localparam int CAP_W  = bqid_pkg::CAP_W;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        bqid_pkg::t_cmd    command;
        logic [DATA_W-1:0] item_value;
        logic [IDX_W-1:0]  index;
        int                gap;
    } t_queue_cmd;

    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] item_out;
        logic [CNT_W-1:0]  count;
        logic              empty_res;
        logic              full_res;
    } t_queue_result;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    bqid_cmd_if cmd_ch ();
    bqid_res_if res_ch ();

    bounded_queue_indexed_delete DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch)
    );

    // Shadow queue state
    logic [DATA_W-1:0] shadow_words [DEPTH];
    int                shadow_fill;
    logic [CAP_W-1:0]  shadow_cap;

    t_queue_cmd    cmd_backlog [$];
    t_queue_result predicted_results [$];
    t_queue_cmd    cur_cmd;

    bit driving;
    int wait_count;
    int stall_left;
    int hold_left;
    int hold_reqs;
    int hold_seen;
    bit src_idle_on;
    bit snk_idle_on;
    int error_count;
    int cycle_count;

    // Clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one command to the shadow queue and return its result
    function automatic t_queue_result queue_exec(t_queue_cmd c);
        t_queue_result r;
        int            cap;
        int            pos;
        cap = (shadow_cap == 0) ? 1
            : ((shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap));
        r.ok       = 1'b0;
        r.item_out = '0;
        pos        = -1;
        case (c.command)
            bqid_pkg::CMD_ENQ: begin
                if (shadow_fill < cap) begin
                    shadow_words[shadow_fill] = c.item_value;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            end
            bqid_pkg::CMD_DEQ: begin
                if (shadow_fill > 0) pos = 0;
            end
            default: begin
                if (int'(c.index) < shadow_fill) pos = int'(c.index);
            end
        endcase
        if (pos >= 0) begin
            r.ok       = 1'b1;
            r.item_out = shadow_words[pos];
            // read leaves the queue alone; dequeue and delete close the gap
            if (c.command != bqid_pkg::CMD_READ) begin
                for (int k = pos; k + 1 < shadow_fill; k++)
                    shadow_words[k] = shadow_words[k + 1];
                shadow_fill--;
            end
        end
        r.count     = CNT_W'(shadow_fill);
        r.empty_res = (shadow_fill == 0);
        r.full_res  = (shadow_fill >= cap);
        return r;
    endfunction

    // Compare the result on the channel with one prediction
    task automatic check_result(t_queue_result want);
        if (res_ch.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, res_ch.ok);
            error_count++;
        end
        if (res_ch.item_out !== want.item_out) begin
            $error("item_out: expected %08h, got %08h", want.item_out, res_ch.item_out);
            error_count++;
        end
        if (res_ch.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, res_ch.count);
            error_count++;
        end
        if (res_ch.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, res_ch.empty_res);
            error_count++;
        end
        if (res_ch.full_res !== want.full_res) begin
            $error("full_res: expected %0d, got %0d", want.full_res, res_ch.full_res);
            error_count++;
        end
    endtask

    // Command driver: predicts on each transfer, then presents the next command
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
            driving    = 1'b0;
            wait_count = 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                predicted_results.push_back(queue_exec(cur_cmd));
                driving = 1'b0;
            end
            if (!driving) begin
                if (cmd_backlog.size() != 0 && wait_count >= cmd_backlog[0].gap) begin
                    cur_cmd = cmd_backlog.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.command    <= cur_cmd.command;
                    cmd_ch.item_value <= cur_cmd.item_value;
                    cmd_ch.index      <= cur_cmd.index;
                    driving    = 1'b1;
                    wait_count = 0;
                end else begin
                    cmd_ch.valid <= 1'b0;
                    if (cmd_backlog.size() != 0) wait_count++;
                end
            end
        end
    end

    // Result monitor with random stalls and the long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    error_count++;
                end else begin
                    check_result(predicted_results.pop_front());
                end
                stall_left = snk_idle_on ? $urandom_range(0, 14) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bounded_queue_indexed_delete_tb: done, errors");
            $finish;
        end
    end

    task automatic push_cmd(bqid_pkg::t_cmd c, logic [DATA_W-1:0] v, logic [IDX_W-1:0] idx);
        t_queue_cmd q;
        q.command    = c;
        q.item_value = v;
        q.index      = idx;
        q.gap        = src_idle_on ? $urandom_range(0, 14) : 0;
        cmd_backlog.push_back(q);
    endtask

    // Random commands; enq_pct sets how hard the queue is pushed toward full
    task automatic push_random(int n, int enq_pct);
        int                r;
        bqid_pkg::t_cmd    c;
        logic [DATA_W-1:0] v;
        logic [IDX_W-1:0]  idx;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < enq_pct) c = bqid_pkg::CMD_ENQ;
            else case (r % 3)
                0:       c = bqid_pkg::CMD_DEQ;
                1:       c = bqid_pkg::CMD_READ;
                default: c = bqid_pkg::CMD_DEL;
            endcase
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = '1;
                default: v = $urandom;
            endcase
            idx = ($urandom_range(0, 1) != 0) ? IDX_W'($urandom_range(0, 15))
                                              : IDX_W'($urandom_range(0, 5));
            push_cmd(c, v, idx);
        end
    endtask

    // Wait until every command has transferred and every result has come back
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || driving || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        shadow_cap = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_idling(bit src_on, bit snk_on);
        @(negedge clk);
        src_idle_on = src_on;
        snk_idle_on = snk_on;
    endtask

    // Stimulus sequence
    initial begin
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = bqid_pkg::CMD_ENQ;
        cmd_ch.item_value = '0;
        cmd_ch.index      = '0;
        res_ch.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        shadow_fill       = 0;
        shadow_cap        = bqid_pkg::CAP_RESET;
        hold_reqs         = 0;
        hold_seen         = 0;
        error_count       = 0;
        cycle_count       = 0;
        src_idle_on       = 1'b1;
        snk_idle_on       = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-queue failures, edge words, reads and deletes in and out of range
        push_cmd(bqid_pkg::CMD_DEQ,  '0, 4'd0);
        push_cmd(bqid_pkg::CMD_READ, '0, 4'd0);
        push_cmd(bqid_pkg::CMD_DEL,  '0, 4'd15);
        push_cmd(bqid_pkg::CMD_ENQ,  32'h0000_0000, 4'd15);
        push_cmd(bqid_pkg::CMD_ENQ,  32'hFFFF_FFFF, 4'd0);
        push_cmd(bqid_pkg::CMD_ENQ,  32'hA5A5_A5A5, 4'd10);
        push_cmd(bqid_pkg::CMD_ENQ,  32'h5A5A_5A5A, 4'd5);
        push_cmd(bqid_pkg::CMD_READ, '1, 4'd0);
        push_cmd(bqid_pkg::CMD_READ, '0, 4'd3);
        push_cmd(bqid_pkg::CMD_READ, '0, 4'd4);
        push_cmd(bqid_pkg::CMD_READ, '0, 4'd15);
        push_cmd(bqid_pkg::CMD_DEL,  '0, 4'd1);
        push_cmd(bqid_pkg::CMD_READ, '0, 4'd1);
        push_cmd(bqid_pkg::CMD_DEL,  '0, 4'd2);
        push_cmd(bqid_pkg::CMD_DEL,  '0, 4'd5);
        push_cmd(bqid_pkg::CMD_DEQ,  '1, 4'd0);
        push_cmd(bqid_pkg::CMD_DEQ,  '0, 4'd0);
        push_cmd(bqid_pkg::CMD_DEQ,  '0, 4'd0);
        push_cmd(bqid_pkg::CMD_ENQ,  32'h1234_5678, 4'd7);
        push_cmd(bqid_pkg::CMD_DEQ,  '0, 4'd0);

        // Full depth, no idling: fill hard, then churn
        wait_drained();
        set_idling(1'b0, 1'b0);
        push_random(150, 70);
        push_random(150, 30);

        // Capacity zero acts as one
        set_capacity(5'd0);
        set_idling(1'b1, 1'b1);
        push_random(80, 50);

        // Capacity one
        set_capacity(5'd1);
        push_random(80, 50);

        // Saturating capacity, with the result side held off for a long stretch
        set_capacity(5'd31);
        @(negedge clk);
        hold_reqs++;
        set_idling(1'b0, 1'b1);
        push_random(200, 55);

        // Capacity dropped below the count: held words stay, enqueue fails
        set_capacity(5'd16);
        for (int i = 0; i < 12; i++) push_cmd(bqid_pkg::CMD_ENQ, $urandom, IDX_W'(i));
        set_capacity(5'd3);
        push_cmd(bqid_pkg::CMD_ENQ,  $urandom, 4'd0);
        push_cmd(bqid_pkg::CMD_READ, '0, 4'd11);
        push_cmd(bqid_pkg::CMD_DEL,  '0, 4'd0);
        push_cmd(bqid_pkg::CMD_DEQ,  '0, 4'd0);
        push_random(40, 40);

        // Mid capacity, sender idling only
        set_capacity(5'd7);
        set_idling(1'b1, 1'b0);
        push_random(200, 50);

        // Full depth again, receiver idling only
        set_capacity(5'd16);
        set_idling(1'b0, 1'b1);
        push_random(250, 50);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("bounded_queue_indexed_delete_tb: done, clean");
        else
            $display("bounded_queue_indexed_delete_tb: done, errors");
        $finish;
    end

endmodule
